### src/bcd_flag_alu_8bit_macros.svh
// ----------------------------------------------------------------------------
// bcd_flag_alu_8bit_macros.svh - assertion macros
// Clocked assertion shorthands for the ALU checker; clk and rst come from scope.
// ----------------------------------------------------------------------------
`ifndef BCD_FLAG_ALU_8BIT_MACROS_SVH
`define BCD_FLAG_ALU_8BIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BFA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bfa check failed");

// Delayed implication, disabled during reset.
`define BFA_ASSERT_LAT2(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
    else $error("bfa latency check failed");

`endif

### src/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg - shared types and constants
// Operation codes, flag and beat structs, BCD adjust constants.
// ----------------------------------------------------------------------------
package bfa_pkg;

  typedef enum logic [3:0] {
    CMD_ADC  = 4'd0,
    CMD_SBC  = 4'd1,
    CMD_CMP  = 4'd2,
    CMD_ASL  = 4'd3,
    CMD_LSR  = 4'd4,
    CMD_ROL  = 4'd5,
    CMD_ROR  = 4'd6,
    CMD_BIT  = 4'd7,
    CMD_AND  = 4'd8,
    CMD_ORA  = 4'd9,
    CMD_EOR  = 4'd10,
    CMD_INC  = 4'd11,
    CMD_DEC  = 4'd12,
    CMD_LOAD = 4'd13
  } cmd_t;

  typedef struct packed {
    logic n;
    logic v;
    logic z;
    logic c;
  } flags_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] a;
    logic [7:0] m;
    logic       c;
    logic       d;
    logic       n;
    logic       v;
    logic       z;
  } req_t;

  typedef struct packed {
    logic [7:0] result;
    flags_t     flags;
  } rsp_t;

  localparam logic [7:0] BCD_LIMIT  = 8'h99;
  localparam logic [7:0] BCD_FIX_LO = 8'h06;
  localparam logic [7:0] BCD_FIX_HI = 8'h60;
  localparam logic [3:0] NIBBLE_MAX = 4'd9;

endpackage

### src/bfa_core.sv
// ----------------------------------------------------------------------------
// bfa_core - ALU datapath
// Single-pass combinational result and flag logic for one beat.
// ----------------------------------------------------------------------------
module bfa_core (
  input  bfa_pkg::req_t req,
  output bfa_pkg::rsp_t rsp
);
  import bfa_pkg::*;

  logic [9:0]  sum;
  logic [4:0]  lo_sum;
  logic [9:0]  adc_adj1;
  logic [9:0]  adc_adj2;
  logic [9:0]  adc_nv;
  logic [15:0] diff;
  logic [15:0] sbc_adj1;
  logic [15:0] sbc_adj2;
  logic [15:0] sbc_fin;
  logic [8:0]  cmp_diff;
  logic [7:0]  res;
  flags_t      fl;

  // Add path: binary sum, then the two decimal corrections in order.
  assign sum      = {2'b00, req.a} + {2'b00, req.m} + {9'd0, req.c};
  assign lo_sum   = {1'b0, req.a[3:0]} + {1'b0, req.m[3:0]} + {4'd0, req.c};
  assign adc_adj1 = (lo_sum > {1'b0, NIBBLE_MAX}) ? sum + {2'b00, BCD_FIX_LO} : sum;
  assign adc_adj2 = (adc_adj1 > {2'b00, BCD_LIMIT}) ? adc_adj1 + {2'b00, BCD_FIX_HI}
                                                     : adc_adj1;
  assign adc_nv   = req.d ? adc_adj1 : sum;

  // Subtract path in 16 bits so wrapped values compare as the byte math does.
  assign diff     = {8'd0, req.a} - {8'd0, req.m} - {15'd0, ~req.c};
  assign sbc_adj1 = ({1'b0, req.a[3:0]} < ({1'b0, req.m[3:0]} + {4'd0, ~req.c}))
                    ? diff - {8'd0, BCD_FIX_LO} : diff;
  assign sbc_adj2 = (sbc_adj1 > {8'd0, BCD_LIMIT}) ? sbc_adj1 - {8'd0, BCD_FIX_HI}
                                                    : sbc_adj1;
  assign sbc_fin  = req.d ? sbc_adj2 : diff;

  assign cmp_diff = {1'b0, req.a} - {1'b0, req.m};

  always_comb begin
    res  = req.a;
    fl.n = req.n;
    fl.v = req.v;
    fl.z = req.z;
    fl.c = req.c;
    case (req.cmd)
      CMD_ADC: begin
        fl.z = (sum[7:0] == 8'd0);
        fl.n = adc_nv[7];
        fl.v = ~(req.a[7] ^ req.m[7]) & (req.a[7] ^ adc_nv[7]);
        if (req.d) begin
          fl.c = (adc_adj2 > {2'b00, BCD_LIMIT});
          res  = adc_adj2[7:0];
        end else begin
          fl.c = sum[8];
          res  = sum[7:0];
        end
      end
      CMD_SBC: begin
        fl.n = diff[7];
        fl.z = (diff[7:0] == 8'd0);
        fl.v = (req.a[7] ^ diff[7]) & (req.a[7] ^ req.m[7]);
        fl.c = (sbc_fin[15:8] == 8'd0);
        res  = sbc_fin[7:0];
      end
      CMD_CMP: begin
        fl.c = ~cmp_diff[8];
        fl.n = cmp_diff[7];
        fl.z = (cmp_diff[7:0] == 8'd0);
      end
      CMD_ASL: begin
        res  = {req.m[6:0], 1'b0};
        fl.c = req.m[7];
      end
      CMD_LSR: begin
        res  = {1'b0, req.m[7:1]};
        fl.c = req.m[0];
      end
      CMD_ROL: begin
        res  = {req.m[6:0], req.c};
        fl.c = req.m[7];
      end
      CMD_ROR: begin
        res  = {req.c, req.m[7:1]};
        fl.c = req.m[0];
      end
      CMD_BIT: begin
        fl.z = ((req.a & req.m) == 8'd0);
        fl.n = req.m[7];
        fl.v = req.m[6];
      end
      CMD_AND:  res = req.a & req.m;
      CMD_ORA:  res = req.a | req.m;
      CMD_EOR:  res = req.a ^ req.m;
      CMD_INC:  res = req.m + 8'd1;
      CMD_DEC:  res = req.m - 8'd1;
      CMD_LOAD: res = req.m;
      default:  res = req.a;
    endcase
    // Shifts, logic ops, inc, dec and load set N and Z from the result.
    if ((req.cmd == CMD_ASL) || (req.cmd == CMD_LSR) || (req.cmd == CMD_ROL) ||
        (req.cmd == CMD_ROR) || (req.cmd == CMD_AND) || (req.cmd == CMD_ORA) ||
        (req.cmd == CMD_EOR) || (req.cmd == CMD_INC) || (req.cmd == CMD_DEC) ||
        (req.cmd == CMD_LOAD)) begin
      fl.n = res[7];
      fl.z = (res == 8'd0);
    end
  end

  assign rsp.result = res;
  assign rsp.flags  = fl;

endmodule

### src/bcd_flag_alu_8bit.sv
// ----------------------------------------------------------------------------
// bcd_flag_alu_8bit - 8-bit ALU with N, V, Z, C flags and BCD add/subtract
// Input register, single-pass datapath, result register.
// ----------------------------------------------------------------------------
// A beat enters when start is high and busy is low; busy is high only while
// rst is asserted, so a new beat can enter on every clock. Each beat is
// captured in the input register, runs through the datapath (bfa_core) and
// lands in the result register. The result is shown for exactly one cycle
// with done high, starting when the result register is loaded. The receiver
// cannot stall: a result not taken in that cycle may be overwritten by the
// next beat. Flags an operation does not touch come back as they went in.
// Unused command codes return accum_in and all flags unchanged. There is no
// configuration and no state beyond the two pipeline registers.
// ----------------------------------------------------------------------------
module bcd_flag_alu_8bit (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [3:0] command,
  input  logic [7:0] accum_in,
  input  logic [7:0] operand,
  input  logic       carry_in,
  input  logic       decimal_in,
  input  logic       negative_in,
  input  logic       overflow_in,
  input  logic       zero_in,
  output logic       done,
  output logic [7:0] result,
  output logic       negative_out,
  output logic       overflow_out,
  output logic       zero_out,
  output logic       carry_out
);
  import bfa_pkg::*;

  req_t req;        // input register payload
  logic req_valid;  // input register holds a beat
  rsp_t rsp_next;   // datapath output
  rsp_t rsp;        // result register payload
  logic accept;

  // Hold off beats only while reset clears the pipeline.
  assign busy   = rst;
  assign accept = start & ~busy;

  // Capture the incoming beat; payload needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      req.cmd <= cmd_t'(command);
      req.a   <= accum_in;
      req.m   <= operand;
      req.c   <= carry_in;
      req.d   <= decimal_in;
      req.n   <= negative_in;
      req.v   <= overflow_in;
      req.z   <= zero_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= accept;
    end
  end

  bfa_core u_core (
    .req (req),
    .rsp (rsp_next)
  );

  // Advance the result into the output register; done strobes for one cycle.
  always_ff @(posedge clk) begin
    if (req_valid) begin
      rsp <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req_valid;
    end
  end

  assign result       = rsp.result;
  assign negative_out = rsp.flags.n;
  assign overflow_out = rsp.flags.v;
  assign zero_out     = rsp.flags.z;
  assign carry_out    = rsp.flags.c;

endmodule

### src/bfa_checker.sv
// ----------------------------------------------------------------------------
// bfa_checker - port-level checks for bcd_flag_alu_8bit
// Latency, no invented results, and pass-through operations.
// ----------------------------------------------------------------------------
`include "bcd_flag_alu_8bit_macros.svh"

module bfa_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [3:0] command,
  input logic [7:0] accum_in,
  input logic [7:0] operand,
  input logic       done,
  input logic [7:0] result,
  input logic       zero_out,
  input logic       negative_out
);
  import bfa_pkg::*;

  `BFA_ASSERT_LAT2(a_beat_returns, start && !busy, done)
  `BFA_ASSERT_IMPL(a_no_extra_beat, done, $past(start && !busy, 2))
  `BFA_ASSERT_IMPL(a_load_passes, done && ($past(command, 2) == CMD_LOAD), (result == $past(operand, 2)) && (zero_out == (result == 8'd0)) && (negative_out == result[7]))
  `BFA_ASSERT_IMPL(a_accum_kept, done && (($past(command, 2) == CMD_CMP) || ($past(command, 2) == CMD_BIT)), result == $past(accum_in, 2))

endmodule

bind bcd_flag_alu_8bit bfa_checker u_bfa_checker (.*);
